### hw/rtl/two_table_key_lookup_macros.svh
// assertion macros used by the checker in ttkl_checker.sv
`ifndef TWO_TABLE_KEY_LOOKUP_MACROS_SVH
`define TWO_TABLE_KEY_LOOKUP_MACROS_SVH

// antecedent implies consequent in the next cycle, quiet during reset
`define TTKL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("two_table_key_lookup: next-cycle check failed");

// antecedent implies consequent in the same cycle, quiet during reset
`define TTKL_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("two_table_key_lookup: same-cycle check failed");

// check that also runs while reset is held
`define TTKL_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("two_table_key_lookup: reset check failed");

`endif

### hw/rtl/ttkl_pkg.sv
package ttkl_pkg;

    // field widths
    localparam int TYPE_W     = 2;
    localparam int INDEX_W    = 12;
    localparam int KEY_W      = 64;
    localparam int OFFSET_W   = 32;
    localparam int MCOUNT_W   = 13;
    localparam int SCOUNT_W   = 11;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // default table depths
    localparam int MAIN_DEPTH_DEFAULT   = 4096;
    localparam int SECOND_DEPTH_DEFAULT = 1024;

    // front-to-back queue
    localparam int Q_DEPTH = 2;
    localparam int Q_PW    = $clog2(Q_DEPTH);
    localparam int Q_CW    = $clog2(Q_DEPTH + 1);

    // request codes
    typedef enum logic [TYPE_W-1:0] {
        REQ_WR_MAIN   = 2'd0,
        REQ_WR_SECOND = 2'd1,
        REQ_LOOKUP    = 2'd2
    } t_req_type;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAIN_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SECOND_ENABLE = 2'd2;

    // one classified word in the queue
    typedef struct packed {
        t_req_type            op;
        logic [INDEX_W-1:0]   index;
        logic [KEY_W-1:0]     key;
        logic [OFFSET_W-1:0]  offset;
    } t_work;

    // configuration seen by the search engine
    typedef struct packed {
        logic [MCOUNT_W-1:0] main_count;
        logic [SCOUNT_W-1:0] second_count;
        logic                second_enable;
    } t_cfg;

endpackage

### hw/rtl/ttkl_req_if.sv
interface ttkl_req_if;
    import ttkl_pkg::*;

    logic                valid;
    logic                ready;
    logic [TYPE_W-1:0]   req_type;
    logic [INDEX_W-1:0]  entry_index;
    logic [KEY_W-1:0]    entry_key;
    logic [OFFSET_W-1:0] entry_offset;
    logic [KEY_W-1:0]    lookup_key;

    modport source (output valid, req_type, entry_index, entry_key, entry_offset, lookup_key,
                    input ready);
    modport sink   (input valid, req_type, entry_index, entry_key, entry_offset, lookup_key,
                    output ready);
endinterface

### hw/rtl/ttkl_rsp_if.sv
interface ttkl_rsp_if;
    import ttkl_pkg::*;

    logic                valid;
    logic                ready;
    logic                found;
    logic                from_second;
    logic [OFFSET_W-1:0] value_offset;

    modport source (output valid, found, from_second, value_offset, input ready);
    modport sink   (input valid, found, from_second, value_offset, output ready);
endinterface

### hw/rtl/ttkl_cfg_if.sv
interface ttkl_cfg_if;
    import ttkl_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### hw/rtl/ttkl_ram.sv
module ttkl_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

### hw/rtl/ttkl_front.sv
module ttkl_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ttkl_req_if.sink        i_req,
    input  logic            i_pop,
    output logic            o_work_valid,
    output ttkl_pkg::t_work o_work
);
    import ttkl_pkg::*;

    t_work           r_slot [Q_DEPTH];
    logic [Q_PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [Q_PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [Q_CW-1:0] r_count, n_count;

    t_work w_work;
    logic  w_keep;
    logic  w_push;
    logic  w_pop;

    // classify the request word, unused codes are dropped
    always_comb begin
        w_work.op     = t_req_type'(i_req.req_type);
        w_work.index  = i_req.entry_index;
        w_work.offset = i_req.entry_offset;
        w_work.key    = i_req.entry_key;
        w_keep        = 1'b0;
        case (i_req.req_type) inside
            REQ_WR_MAIN, REQ_WR_SECOND: begin
                w_keep = 1'b1;
            end
            REQ_LOOKUP: begin
                w_work.key = i_req.lookup_key;
                w_keep     = 1'b1;
            end
            default: begin
                w_keep = 1'b0;
            end
        endcase
    end

    assign i_req.ready = (r_count != Q_CW'(Q_DEPTH));
    assign w_push      = i_req.valid && i_req.ready && w_keep;
    assign w_pop       = i_pop && (r_count != '0);

    // queue pointers and fill level
    always_comb begin
        n_wr_ptr = w_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = w_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        case ({w_push, w_pop})
            2'b10:   n_count = r_count + 1'b1;
            2'b01:   n_count = r_count - 1'b1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_slot[r_wr_ptr] <= w_work;
        end
    end

    assign o_work_valid = (r_count != '0);
    assign o_work       = r_slot[r_rd_ptr];
endmodule

### hw/rtl/ttkl_back.sv
module ttkl_back #(
    parameter int MAIN_DEPTH   = ttkl_pkg::MAIN_DEPTH_DEFAULT,
    parameter int SECOND_DEPTH = ttkl_pkg::SECOND_DEPTH_DEFAULT
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_work_valid,
    input  ttkl_pkg::t_work i_work,
    output logic            o_pop,
    input  ttkl_pkg::t_cfg  i_cfg,
    ttkl_rsp_if.source      o_rsp
);
    import ttkl_pkg::*;

    localparam int MAW     = (MAIN_DEPTH > 1) ? $clog2(MAIN_DEPTH) : 1;
    localparam int SAW     = (SECOND_DEPTH > 1) ? $clog2(SECOND_DEPTH) : 1;
    localparam int AW      = (MAW > SAW) ? MAW : SAW;
    localparam int MAXD    = (MAIN_DEPTH > SECOND_DEPTH) ? MAIN_DEPTH : SECOND_DEPTH;
    localparam int CW      = $clog2(MAXD + 1);
    localparam int ENTRY_W = KEY_W + OFFSET_W;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_PROBE = 4'b0010,
        S_CMP   = 4'b0100,
        S_DONE  = 4'b1000
    } t_bstate;

    t_bstate             r_state, n_state;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_end, n_end;
    logic [AW-1:0]       r_mid, n_mid;
    logic                r_second, n_second;
    logic [KEY_W-1:0]    r_key, n_key;
    logic                r_hit, n_hit;
    logic [OFFSET_W-1:0] r_off, n_off;

    logic                r_out_valid, n_out_valid;
    logic                r_out_found;
    logic                r_out_second;
    logic [OFFSET_W-1:0] r_out_off;

    logic [CW-1:0]      w_main_cnt, w_second_cnt;
    logic [CW:0]        w_sum;
    logic [AW-1:0]      w_mid;
    logic               w_more;
    logic [ENTRY_W-1:0] w_main_rd, w_second_rd, w_rd;
    logic [KEY_W-1:0]   w_rd_key;
    logic               w_load;
    logic               w_we_main, w_we_second;

    // searched range saturates at the table depth
    assign w_main_cnt   = (32'(i_cfg.main_count) > 32'(MAIN_DEPTH)) ?
                          CW'(MAIN_DEPTH) : CW'(i_cfg.main_count);
    assign w_second_cnt = (32'(i_cfg.second_count) > 32'(SECOND_DEPTH)) ?
                          CW'(SECOND_DEPTH) : CW'(i_cfg.second_count);

    // probe point over the open range [lo, end)
    assign w_sum  = {1'b0, r_lo} + {1'b0, r_end} - (CW + 1)'(1);
    assign w_mid  = AW'(w_sum[CW:1]);
    assign w_more = (r_lo < r_end);

    // table writes are carried out straight from the queue head
    assign o_pop       = (r_state == S_IDLE) && i_work_valid;
    assign w_we_main   = o_pop && (i_work.op == REQ_WR_MAIN) &&
                         (32'(i_work.index) < 32'(MAIN_DEPTH));
    assign w_we_second = o_pop && (i_work.op == REQ_WR_SECOND) &&
                         (32'(i_work.index) < 32'(SECOND_DEPTH));

    ttkl_ram #(.WIDTH(ENTRY_W), .DEPTH(MAIN_DEPTH), .AW(MAW)) u_main_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_main),
        .i_waddr (MAW'(i_work.index)),
        .i_wdata ({i_work.key, i_work.offset}),
        .i_raddr (MAW'(w_mid)),
        .o_rdata (w_main_rd)
    );

    ttkl_ram #(.WIDTH(ENTRY_W), .DEPTH(SECOND_DEPTH), .AW(SAW)) u_second_ram (
        .i_clk   (i_clk),
        .i_we    (w_we_second),
        .i_waddr (SAW'(i_work.index)),
        .i_wdata ({i_work.key, i_work.offset}),
        .i_raddr (SAW'(w_mid)),
        .o_rdata (w_second_rd)
    );

    assign w_rd     = r_second ? w_second_rd : w_main_rd;
    assign w_rd_key = w_rd[ENTRY_W-1:OFFSET_W];

    // result moves to the output register once it is free
    assign w_load = (r_state == S_DONE) && (!r_out_valid || o_rsp.ready);

    // search sequencer
    always_comb begin
        n_state  = r_state;
        n_lo     = r_lo;
        n_end    = r_end;
        n_mid    = r_mid;
        n_second = r_second;
        n_key    = r_key;
        n_hit    = r_hit;
        n_off    = r_off;
        unique case (r_state)
            S_IDLE: begin
                if (o_pop && (i_work.op == REQ_LOOKUP)) begin
                    n_key    = i_work.key;
                    n_lo     = '0;
                    n_end    = w_main_cnt;
                    n_second = 1'b0;
                    n_state  = S_PROBE;
                end
            end
            S_PROBE: begin
                if (w_more) begin
                    n_mid   = w_mid;
                    n_state = S_CMP;
                end else if (!r_second && i_cfg.second_enable) begin
                    n_second = 1'b1;
                    n_lo     = '0;
                    n_end    = w_second_cnt;
                end else begin
                    n_hit   = 1'b0;
                    n_off   = '0;
                    n_state = S_DONE;
                end
            end
            S_CMP: begin
                if (r_key == w_rd_key) begin
                    n_hit   = 1'b1;
                    n_off   = w_rd[OFFSET_W-1:0];
                    n_state = S_DONE;
                end else if (r_key < w_rd_key) begin
                    n_end   = CW'(r_mid);
                    n_state = S_PROBE;
                end else begin
                    n_lo    = CW'(r_mid) + CW'(1);
                    n_state = S_PROBE;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // output register handshake
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_rsp.ready) begin
            n_out_valid = 1'b0;
        end
        if (w_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // search and result payload
    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_end    <= n_end;
        r_mid    <= n_mid;
        r_second <= n_second;
        r_key    <= n_key;
        r_hit    <= n_hit;
        r_off    <= n_off;
        if (w_load) begin
            r_out_found  <= r_hit;
            r_out_second <= r_hit && r_second;
            r_out_off    <= r_off;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.found        = r_out_found;
    assign o_rsp.from_second  = r_out_second;
    assign o_rsp.value_offset = r_out_off;
endmodule

### hw/rtl/two_table_key_lookup.sv
// two-table key lookup: sorted main and secondary key tables with binary search
//
// i_req takes request words: write main entry, write secondary entry or lookup.
// writes produce no response; each lookup produces exactly one word on o_rsp
// with found, from_second and value_offset (zero on a miss). request code 3 is
// taken and dropped. i_cfg writes main_count, second_count and second_enable;
// it is always ready. the user is to write it only while the block is idle;
// the block itself does not enforce this. a two-word queue sits between the
// request port and the search engine, so the request side takes up to two words
// while a search runs or a response stalls. a write is done straight from the
// queue head while the engine is idle. a lookup probes the main table and, on a
// main miss with second_enable set, the secondary table, with up to 13 probes in
// the main and 11 in the secondary table at the default depths; each probe is
// one registered RAM read followed by one key compare.
// the response register holds its word while o_rsp.ready is low; the engine
// then waits in front of it, nothing leaves the queue, and i_req.ready drops
// once two words are waiting. reset clears the queue, the engine state, the
// response valid and all configuration registers; table contents are
// undefined until written.
module two_table_key_lookup #(
    parameter int MAIN_DEPTH   = ttkl_pkg::MAIN_DEPTH_DEFAULT,
    parameter int SECOND_DEPTH = ttkl_pkg::SECOND_DEPTH_DEFAULT
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ttkl_req_if.sink   i_req,
    ttkl_rsp_if.source o_rsp,
    ttkl_cfg_if.sink   i_cfg
);
    import ttkl_pkg::*;

    logic [MCOUNT_W-1:0] r_main_count;
    logic [SCOUNT_W-1:0] r_second_count;
    logic                r_second_enable;

    t_cfg  w_cfg;
    t_work w_work;
    logic  w_work_valid;
    logic  w_pop;

    // configuration registers
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_count    <= '0;
            r_second_count  <= '0;
            r_second_enable <= 1'b0;
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                CFG_MAIN_COUNT:    r_main_count    <= i_cfg.data[MCOUNT_W-1:0];
                CFG_SECOND_COUNT:  r_second_count  <= i_cfg.data[SCOUNT_W-1:0];
                CFG_SECOND_ENABLE: r_second_enable <= i_cfg.data[0];
                default:           r_second_enable <= r_second_enable;
            endcase
        end
    end

    assign w_cfg.main_count    = r_main_count;
    assign w_cfg.second_count  = r_second_count;
    assign w_cfg.second_enable = r_second_enable;

    // request classification and queue
    ttkl_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (i_req),
        .i_pop        (w_pop),
        .o_work_valid (w_work_valid),
        .o_work       (w_work)
    );

    // table writes and search engine
    ttkl_back #(
        .MAIN_DEPTH   (MAIN_DEPTH),
        .SECOND_DEPTH (SECOND_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_work_valid (w_work_valid),
        .i_work       (w_work),
        .o_pop        (w_pop),
        .i_cfg        (w_cfg),
        .o_rsp        (o_rsp)
    );
endmodule

### hw/rtl/ttkl_checker.sv
`include "two_table_key_lookup_macros.svh"

module ttkl_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_rsp_valid,
    input logic                          i_rsp_ready,
    input logic                          i_rsp_found,
    input logic                          i_rsp_from_second,
    input logic [ttkl_pkg::OFFSET_W-1:0] i_rsp_value_offset
);
    import ttkl_pkg::*;

    // a stalled response word stays up
    `TTKL_ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid)

    // a stalled response word keeps its fields
    `TTKL_ASSERT_NEXT(a_rsp_stable, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, $stable(i_rsp_found) && $stable(i_rsp_from_second) && $stable(i_rsp_value_offset))

    // a miss reports neither table nor offset
    `TTKL_ASSERT_SAME(a_miss_clean, i_clk, i_rst_n, i_rsp_valid && !i_rsp_found, !i_rsp_from_second && (i_rsp_value_offset == '0))

    // no response word right after reset
    `TTKL_ASSERT_ALWAYS_NEXT(a_reset_quiet, i_clk, !i_rst_n, !i_rsp_valid)
endmodule

bind two_table_key_lookup ttkl_checker u_checker (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_rsp_valid        (o_rsp.valid),
    .i_rsp_ready        (o_rsp.ready),
    .i_rsp_found        (o_rsp.found),
    .i_rsp_from_second  (o_rsp.from_second),
    .i_rsp_value_offset (o_rsp.value_offset)
);

### dv/ttkl_result_checker.sv
`timescale 1ns / 1ps

module ttkl_result_checker #(
    parameter int MAIN_DEPTH   = ttkl_pkg::MAIN_DEPTH_DEFAULT,
    parameter int SECOND_DEPTH = ttkl_pkg::SECOND_DEPTH_DEFAULT
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ttkl_req_if  i_req,
    ttkl_rsp_if  i_rsp,
    ttkl_cfg_if  i_cfg,
    output int   o_pending,
    output int   o_mismatches
);
    import ttkl_pkg::*;

    typedef struct packed {
        logic [KEY_W-1:0]    lookup_key;
        logic                found;
        logic                from_second;
        logic [OFFSET_W-1:0] value_offset;
    } t_lookup_result;

    // shadow copy of both tables and the search configuration
    bit [KEY_W-1:0]      main_keys      [MAIN_DEPTH];
    bit [OFFSET_W-1:0]   main_offsets   [MAIN_DEPTH];
    bit [KEY_W-1:0]      second_keys    [SECOND_DEPTH];
    bit [OFFSET_W-1:0]   second_offsets [SECOND_DEPTH];
    logic [MCOUNT_W-1:0] main_count;
    logic [SCOUNT_W-1:0] second_count;
    logic                second_enable;

    t_lookup_result pending_lookups [$];
    t_lookup_result oldest;
    int             mismatch_total = 0;

    assign o_mismatches = mismatch_total;

    task automatic report_mismatch(input string what);
        if (mismatch_total < 100)
            $display("[%0t] mismatch: %s", $time, what);
        mismatch_total++;
    endtask

    // binary search over the valid slots of one table
    function automatic bit probe_table(input bit in_second, input logic [KEY_W-1:0] want,
                                       output logic [OFFSET_W-1:0] hit_offset);
        int             lo;
        int             hi;
        int             mid;
        int             span;
        bit [KEY_W-1:0] probe_key;
        hit_offset = '0;
        span = in_second ? int'(second_count) : int'(main_count);
        if (in_second && span > SECOND_DEPTH)
            span = SECOND_DEPTH;
        if (!in_second && span > MAIN_DEPTH)
            span = MAIN_DEPTH;
        lo = 0;
        hi = span - 1;
        while (lo <= hi) begin
            mid = (lo + hi) / 2;
            probe_key = in_second ? second_keys[mid] : main_keys[mid];
            if (want == probe_key) begin
                hit_offset = in_second ? second_offsets[mid] : main_offsets[mid];
                return 1'b1;
            end
            if (want < probe_key)
                hi = mid - 1;
            else
                lo = mid + 1;
        end
        return 1'b0;
    endfunction

    // main table first, secondary only on a main miss when enabled
    function automatic t_lookup_result predict_lookup(input logic [KEY_W-1:0] want);
        t_lookup_result      res;
        logic [OFFSET_W-1:0] off;
        res = '0;
        res.lookup_key = want;
        if (probe_table(1'b0, want, off)) begin
            res.found = 1'b1;
            res.value_offset = off;
        end else if (second_enable && probe_table(1'b1, want, off)) begin
            res.found = 1'b1;
            res.from_second = 1'b1;
            res.value_offset = off;
        end
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            main_count = '0;
            second_count = '0;
            second_enable = 1'b0;
            pending_lookups.delete();
            o_pending <= 0;
        end else begin
            // response word against the oldest lookup
            if (i_rsp.valid && i_rsp.ready) begin
                if (pending_lookups.size() == 0) begin
                    report_mismatch($sformatf("response found=%b offset=%h with no lookup waiting",
                                              i_rsp.found, i_rsp.value_offset));
                end else begin
                    oldest = pending_lookups.pop_front();
                    if (i_rsp.found !== oldest.found)
                        report_mismatch($sformatf("key %h found got %b want %b",
                                                  oldest.lookup_key, i_rsp.found, oldest.found));
                    if (i_rsp.from_second !== oldest.from_second)
                        report_mismatch($sformatf("key %h from_second got %b want %b",
                                                  oldest.lookup_key, i_rsp.from_second,
                                                  oldest.from_second));
                    if (i_rsp.value_offset !== oldest.value_offset)
                        report_mismatch($sformatf("key %h value_offset got %h want %h",
                                                  oldest.lookup_key, i_rsp.value_offset,
                                                  oldest.value_offset));
                end
            end

            // register writes
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_MAIN_COUNT:    main_count = i_cfg.data[MCOUNT_W-1:0];
                    CFG_SECOND_COUNT:  second_count = i_cfg.data[SCOUNT_W-1:0];
                    CFG_SECOND_ENABLE: second_enable = i_cfg.data[0];
                    default: ;
                endcase
            end

            // request word: table write or lookup
            if (i_req.valid && i_req.ready) begin
                case (i_req.req_type)
                    REQ_WR_MAIN: begin
                        if (i_req.entry_index < MAIN_DEPTH) begin
                            main_keys[i_req.entry_index] = i_req.entry_key;
                            main_offsets[i_req.entry_index] = i_req.entry_offset;
                        end
                    end
                    REQ_WR_SECOND: begin
                        if (i_req.entry_index < SECOND_DEPTH) begin
                            second_keys[i_req.entry_index] = i_req.entry_key;
                            second_offsets[i_req.entry_index] = i_req.entry_offset;
                        end
                    end
                    REQ_LOOKUP: pending_lookups.push_back(predict_lookup(i_req.lookup_key));
                    default: ;
                endcase
            end

            o_pending <= pending_lookups.size();
        end
    end

endmodule

### dv/two_table_key_lookup_test.sv
`timescale 1ns / 1ps

module two_table_key_lookup_test;
    import ttkl_pkg::*;

    localparam int MAIN_SLOTS   = MAIN_DEPTH_DEFAULT;
    localparam int SECOND_SLOTS = SECOND_DEPTH_DEFAULT;
    localparam int RANDOM_ITEMS = 1600;
    localparam int DRAIN_CYCLES = 64;
    localparam int CYCLE_LIMIT  = 1_000_000;

    localparam logic [TYPE_W-1:0]    REQ_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    localparam logic [KEY_W-1:0] KEY_MAX         = '1;
    localparam logic [KEY_W-1:0] KEY_A           = 64'h4100_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_AB          = 64'h4142_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_ABC         = 64'h4142_4300_0000_0000;
    localparam logic [KEY_W-1:0] KEY_SECOND_LOW  = 64'h3000_0000_0000_0000;
    localparam logic [KEY_W-1:0] KEY_SECOND_HIGH = 64'h8000_0000_0000_0000;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ttkl_req_if req_bus();
    ttkl_rsp_if rsp_bus();
    ttkl_cfg_if cfg_bus();

    int pending_count;
    int mismatch_count;
    int cycle_count;

    // what the stimulus side knows about table contents
    bit [KEY_W-1:0] main_copy      [MAIN_SLOTS];
    bit [KEY_W-1:0] second_copy    [SECOND_SLOTS];
    bit             main_written   [MAIN_SLOTS];
    bit             second_written [SECOND_SLOTS];

    int burst_left;
    int main_span;
    int second_span;

    two_table_key_lookup dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_bus),
        .o_rsp   (rsp_bus),
        .i_cfg   (cfg_bus)
    );

    ttkl_result_checker u_result_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_bus),
        .i_rsp        (rsp_bus),
        .i_cfg        (cfg_bus),
        .o_pending    (pending_count),
        .o_mismatches (mismatch_count)
    );

    always #5 i_clk = ~i_clk;

    function automatic logic [KEY_W-1:0] random_key();
        return {$urandom, $urandom};
    endfunction

    function automatic bit has_gap(input bit in_second, input int count);
        for (int i = 0; i < count; i++) begin
            if (in_second ? !second_written[i] : !main_written[i])
                return 1'b1;
        end
        return 1'b0;
    endfunction

    // one request word, sent in bursts with random gaps between them
    task automatic send_item(input logic [TYPE_W-1:0] kind, input logic [INDEX_W-1:0] slot,
                             input logic [KEY_W-1:0] ekey, input logic [OFFSET_W-1:0] eoff,
                             input logic [KEY_W-1:0] lkey);
        int gap;
        if (burst_left <= 0) begin
            gap = $urandom_range(1, 12);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                      : $urandom_range(1, 30);
        end
        burst_left--;
        req_bus.valid        <= 1'b1;
        req_bus.req_type     <= kind;
        req_bus.entry_index  <= slot;
        req_bus.entry_key    <= ekey;
        req_bus.entry_offset <= eoff;
        req_bus.lookup_key   <= lkey;
        @(posedge i_clk);
        while (!req_bus.ready) @(posedge i_clk);
        if (kind == REQ_WR_MAIN) begin
            main_copy[slot] = ekey;
            main_written[slot] = 1'b1;
        end else if (kind == REQ_WR_SECOND && slot < SECOND_SLOTS) begin
            second_copy[slot] = ekey;
            second_written[slot] = 1'b1;
        end
    endtask

    task automatic write_entry(input logic [TYPE_W-1:0] kind, input int slot,
                               input logic [KEY_W-1:0] key);
        send_item(kind, slot[INDEX_W-1:0], key, $urandom, random_key());
    endtask

    task automatic lookup(input logic [KEY_W-1:0] key);
        logic [INDEX_W-1:0] junk_slot;
        junk_slot = $urandom_range(0, MAIN_SLOTS - 1);
        send_item(REQ_LOOKUP, junk_slot, random_key(), $urandom, key);
    endtask

    // strictly ascending keys spread over the whole key range
    task automatic load_sorted(input bit in_second, input int count, input bit pin_ends);
        logic [KEY_W-1:0] stride;
        logic [KEY_W-1:0] key;
        stride = KEY_MAX / (count + 1);
        for (int i = 0; i < count; i++) begin
            key = stride * i + random_key() % stride;
            if (pin_ends && i == 0)
                key = '0;
            if (pin_ends && i == count - 1)
                key = KEY_MAX;
            write_entry(in_second ? REQ_WR_SECOND : REQ_WR_MAIN, i, key);
        end
    endtask

    // wait for the last response, then let trailing writes drain
    task automatic wait_idle();
        req_bus.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_count != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= data;
        @(posedge i_clk);
        while (!cfg_bus.ready) @(posedge i_clk);
    endtask

    // unused upper data bits are filled with noise
    task automatic configure(input int m, input int s, input bit e);
        logic [CFG_DATA_W-SCOUNT_W-1:0] count_noise;
        logic [CFG_DATA_W-2:0]          enable_noise;
        count_noise = $urandom_range(0, 3);
        enable_noise = ($urandom_range(0, 1) == 1) ? $urandom : 0;
        wait_idle();
        if ($urandom_range(0, 3) == 0)
            set_reg(CFG_UNUSED, $urandom);
        set_reg(CFG_MAIN_COUNT, m[CFG_DATA_W-1:0]);
        set_reg(CFG_SECOND_COUNT, {count_noise, s[SCOUNT_W-1:0]});
        set_reg(CFG_SECOND_ENABLE, {enable_noise, e});
        cfg_bus.valid <= 1'b0;
        main_span = (m > MAIN_SLOTS) ? MAIN_SLOTS : m;
        second_span = (s > SECOND_SLOTS) ? SECOND_SLOTS : s;
    endtask

    // response side stall pattern, re-chosen every window
    initial begin
        int ready_mode;
        int window_left;
        ready_mode = 0;
        window_left = 0;
        rsp_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (window_left == 0) begin
                ready_mode = $urandom_range(0, 3);
                window_left = $urandom_range(20, 150);
            end else begin
                window_left--;
            end
            case (ready_mode)
                0: rsp_bus.ready <= 1'b1;
                1: rsp_bus.ready <= ($urandom_range(0, 1) == 1);
                2: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_bus.ready <= ((window_left % 16) < 4);
            endcase
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int               phase;
        int               done;
        int               quota;
        int               counted;
        int               pick;
        int               m;
        int               s;
        bit               e;
        bit               pin;
        int               slot;
        logic [KEY_W-1:0] key;

        i_rst_n              <= 1'b0;
        req_bus.valid        <= 1'b0;
        req_bus.req_type     <= REQ_WR_MAIN;
        req_bus.entry_index  <= '0;
        req_bus.entry_key    <= '0;
        req_bus.entry_offset <= '0;
        req_bus.lookup_key   <= '0;
        cfg_bus.valid        <= 1'b0;
        cfg_bus.index        <= CFG_MAIN_COUNT;
        cfg_bus.data         <= '0;
        burst_left = 0;
        main_span = 0;
        second_span = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty tables after reset: lookups miss, code 3 and out-of-range writes dropped
        lookup('0);
        send_item(REQ_UNUSED, '1, KEY_MAX, '1, KEY_MAX);
        send_item(REQ_WR_SECOND, '1, KEY_MAX, '1, KEY_MAX);
        send_item(REQ_WR_SECOND, SECOND_SLOTS, random_key(), $urandom, random_key());

        // small sorted tables holding the key extremes, one key in both tables
        send_item(REQ_WR_MAIN, 0, '0, '0, random_key());
        send_item(REQ_WR_MAIN, 1, KEY_AB, '1, random_key());
        write_entry(REQ_WR_MAIN, 2, KEY_ABC);
        write_entry(REQ_WR_MAIN, 3, KEY_MAX);
        write_entry(REQ_WR_SECOND, 0, KEY_SECOND_LOW);
        write_entry(REQ_WR_SECOND, 1, KEY_AB);
        write_entry(REQ_WR_SECOND, 2, KEY_SECOND_HIGH);
        lookup(KEY_AB);

        configure(4, 3, 1'b1);
        lookup('0);
        lookup(KEY_MAX);
        lookup(KEY_ABC);
        lookup(KEY_SECOND_LOW);
        lookup(KEY_SECOND_HIGH);
        lookup(KEY_AB);
        lookup(KEY_A);
        lookup(64'd1);

        // fallback disabled
        configure(4, 3, 1'b0);
        lookup(KEY_SECOND_LOW);

        // one-entry tables
        configure(1, 1, 1'b1);
        lookup(KEY_MAX);
        lookup(KEY_SECOND_LOW);

        // random phases: full tables, counts above depth, then mostly small tables
        phase = 0;
        done = 0;
        while (done < RANDOM_ITEMS) begin
            if (phase == 0) begin
                m = MAIN_SLOTS;
                s = SECOND_SLOTS;
                e = 1'b1;
            end else if (phase == 1) begin
                m = 8191;
                s = 2047;
                e = 1'b1;
            end else begin
                pick = $urandom_range(0, 9);
                m = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 8191)
                                                  : $urandom_range(1, 48);
                pick = $urandom_range(0, 9);
                s = (pick == 0) ? 0 : (pick == 1) ? $urandom_range(1, 2047)
                                                  : $urandom_range(1, 48);
                e = ($urandom_range(0, 3) != 0);
            end
            pin = ($urandom_range(0, 3) == 0);
            main_span = (m > MAIN_SLOTS) ? MAIN_SLOTS : m;
            second_span = (s > SECOND_SLOTS) ? SECOND_SLOTS : s;

            // every slot a search can reach is written before it is searched
            if (main_span > 0 && (main_span <= 64 || has_gap(1'b0, main_span)))
                load_sorted(1'b0, main_span, pin);
            if (e && second_span > 0 && (second_span <= 64 || has_gap(1'b1, second_span)))
                load_sorted(1'b1, second_span, pin);
            configure(m, s, e);

            quota = (main_span > 64 || second_span > 64) ? 120 : $urandom_range(20, 60);
            counted = 0;
            while (counted < quota) begin
                pick = $urandom_range(0, 99);
                if (pick < 25 && main_span > 0) begin
                    lookup(main_copy[$urandom_range(0, main_span - 1)]);
                    counted++;
                end else if (pick < 40 && second_span > 0) begin
                    lookup(second_copy[$urandom_range(0, second_span - 1)]);
                    counted++;
                end else if (pick < 48 && main_span > 0) begin
                    // neighbor of a stored key
                    key = main_copy[$urandom_range(0, main_span - 1)];
                    lookup(pick[0] ? key + 64'd1 : key - 64'd1);
                    counted++;
                end else if (pick < 60) begin
                    lookup((pick == 58) ? '0 : (pick == 59) ? KEY_MAX : random_key());
                    counted++;
                end else if (pick < 75) begin
                    // rewrite keeps the order, a random key may break it
                    slot = (main_span > 0 && $urandom_range(0, 3) != 0)
                           ? $urandom_range(0, main_span - 1) : $urandom_range(0, MAIN_SLOTS - 1);
                    key = ($urandom_range(0, 1) == 1) ? main_copy[slot] : random_key();
                    write_entry(REQ_WR_MAIN, slot, key);
                    counted++;
                end else if (pick < 85) begin
                    slot = $urandom_range(0, SECOND_SLOTS - 1);
                    key = ($urandom_range(0, 1) == 1) ? second_copy[slot] : random_key();
                    write_entry(REQ_WR_SECOND, slot, key);
                    counted++;
                end else if (pick < 93) begin
                    lookup(random_key());
                    counted++;
                end else if (pick < 97) begin
                    send_item(REQ_UNUSED, $urandom_range(0, MAIN_SLOTS - 1), random_key(),
                              $urandom, random_key());
                end else begin
                    write_entry(REQ_WR_SECOND, $urandom_range(SECOND_SLOTS, MAIN_SLOTS - 1),
                                random_key());
                end
            end
            done += quota;
            phase++;
        end

        wait_idle();
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

### files.f
+incdir+hw/rtl
hw/rtl/ttkl_pkg.sv
hw/rtl/ttkl_req_if.sv
hw/rtl/ttkl_rsp_if.sv
hw/rtl/ttkl_cfg_if.sv
hw/rtl/ttkl_ram.sv
hw/rtl/ttkl_front.sv
hw/rtl/ttkl_back.sv
hw/rtl/two_table_key_lookup.sv
hw/rtl/ttkl_checker.sv
dv/ttkl_result_checker.sv
dv/two_table_key_lookup_test.sv
